/* hdl/sdie_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdie_pkg
// Shared types and constants for the single-digit infix evaluator: operator
// and error codes, sequencer states and the request/response bundles of the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
package sdie_pkg;

    localparam int unsigned DATA_W = 8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CHAR = 2'd1,
        ERR_FORM = 2'd2,
        ERR_DIV0 = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PARSE,
        ST_OP,
        ST_REDUCE,
        ST_FINAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div0;
    } alu_rsp_t;

endpackage : sdie_pkg
`default_nettype wire

/* hdl/sdie_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdie_alu
// Shared arithmetic unit. Add, subtract and multiply register their result
// and done in the cycle after start; signed divide runs a restoring divider
// on magnitudes, one quotient bit per cycle, and truncates toward zero.
// ----------------------------------------------------------------------------
module sdie_alu (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sdie_pkg::alu_req_t   req,
    input  wire logic [7:0]           a,
    input  wire logic [7:0]           b,
    output sdie_pkg::alu_rsp_t        rsp,
    output logic [7:0]                result
);
    import sdie_pkg::*;

    logic        busy_reg;
    logic [2:0]  cnt_reg;
    logic        done_reg;
    logic        div0_reg;
    logic [7:0]  res_reg;
    logic [7:0]  q_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  bmag_reg;
    logic        neg_reg;

    logic [15:0] prod;
    logic [7:0]  amag;
    logic [7:0]  bmag;
    logic [8:0]  rem_sh;
    logic        fits;
    logic [7:0]  rem_step;
    logic [7:0]  q_step;
    logic [8:0]  diff;

    assign prod = a * b;
    assign amag = a[7] ? 8'(-a) : a;
    assign bmag = b[7] ? 8'(-b) : b;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh   = {rem_reg, q_reg[7]};
    assign diff     = rem_sh - {1'b0, bmag_reg};
    assign fits     = (rem_sh >= {1'b0, bmag_reg});
    assign rem_step = fits ? diff[7:0] : rem_sh[7:0];
    assign q_step   = {q_reg[6:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                div0_reg <= 1'b0;
                case (req.op)
                    OP_ADD: begin
                        res_reg  <= a + b;
                        done_reg <= 1'b1;
                    end
                    OP_SUB: begin
                        res_reg  <= a - b;
                        done_reg <= 1'b1;
                    end
                    OP_MUL: begin
                        res_reg  <= prod[7:0];
                        done_reg <= 1'b1;
                    end
                    default: begin
                        if (b == 8'd0) begin
                            div0_reg <= 1'b1;
                            done_reg <= 1'b1;
                        end else begin
                            busy_reg <= 1'b1;
                            cnt_reg  <= 3'd0;
                            q_reg    <= amag;
                            rem_reg  <= 8'd0;
                            bmag_reg <= bmag;
                            neg_reg  <= a[7] ^ b[7];
                        end
                    end
                endcase
            end else if (busy_reg) begin
                q_reg   <= q_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= neg_reg ? 8'(-q_step) : q_step;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.div0 = div0_reg;
    assign result   = res_reg;

endmodule : sdie_alu
`default_nettype wire

/* hdl/single_digit_infix_evaluator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// single_digit_infix_evaluator
// Evaluates an infix expression of single-digit numbers with + - * /, one
// ASCII character per input item, using a three-value stack and one shared
// arithmetic unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata[7:0] carries one character; s_tlast marks the final one. Spaces
//   are skipped, * and / bind tighter than + and -, equal ranks go left to
//   right. Only the item with s_tlast high produces a result on m_*:
//   m_tdata[7:0] is the signed 8-bit value (wraps like a C char) and
//   m_tdata[9:8] the error code (0 ok, 1 bad character, 2 malformed, 3 divide
//   by zero); the value is 0 whenever the error is not 0.
// Timing:
//   s_tready drops for the item's whole evaluation. A digit or space passes
//   through the parse step, an operator also through the operator step; each
//   reduction waits in the reduce state for the shared unit, whose divide runs
//   bit-serially. A last item adds up to two reductions, a final check and a
//   step that loads the result register.
// Reset and stall:
//   aresetn (synchronous, active low) empties the stack and clears any error.
//   The result sits in an output register; new characters are accepted while
//   it waits, but the next result holds the block until m_tready takes it.
// ----------------------------------------------------------------------------
module single_digit_infix_evaluator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [7:0] value, [9:8] error, [15:10] zero
);
    import sdie_pkg::*;

    state_t      state_reg, state_next;
    logic [7:0]  sym_reg, sym_next;
    logic        last_reg, last_next;
    logic [2:0]  level_reg, level_next;
    logic        expect_reg, expect_next;
    err_t        err_reg, err_next;
    logic        ret_final_reg, ret_final_next;
    logic [7:0]  v0_reg, v0_next;
    logic [7:0]  v1_reg, v1_next;
    logic [7:0]  v2_reg, v2_next;
    op_t         op0_reg, op0_next;
    op_t         op1_reg, op1_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_val_reg, out_val_next;
    err_t        out_err_reg, out_err_next;

    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    logic [7:0]  alu_a;
    logic [7:0]  alu_b;
    logic [7:0]  alu_res;

    logic        lo;
    op_t         top_op;
    op_t         sym_op;
    logic        is_op;
    logic        is_digit;
    logic        is_space;
    logic        ge3;
    logic        need_reduce;
    state_t      tail_state;

    // bottom operand index of the top three stack items
    assign lo     = level_reg[2] & level_reg[0];
    assign alu_a  = lo ? v1_reg : v0_reg;
    assign alu_b  = lo ? v2_reg : v1_reg;
    assign top_op = lo ? op1_reg : op0_reg;
    assign ge3    = (level_reg >= 3'd3);

    assign is_digit = (sym_reg >= CH_ZERO) && (sym_reg <= CH_NINE);
    assign is_space = (sym_reg == CH_SPACE);

    always_comb begin
        is_op  = 1'b1;
        sym_op = OP_ADD;
        case (sym_reg)
            CH_PLUS:  sym_op = OP_ADD;
            CH_MINUS: sym_op = OP_SUB;
            CH_STAR:  sym_op = OP_MUL;
            CH_SLASH: sym_op = OP_DIV;
            default:  is_op  = 1'b0;
        endcase
    end

    // * and / fold only a pending * or /; + and - fold everything
    assign need_reduce = ge3 && (sym_op[1] ? top_op[1] : 1'b1);
    assign tail_state  = last_reg ? ST_FINAL : ST_IDLE;

    sdie_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (alu_b),
        .rsp     (alu_rsp),
        .result  (alu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            level_reg   <= 3'd0;
            expect_reg  <= 1'b1;
            err_reg     <= ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            expect_reg  <= expect_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg       <= sym_next;
        last_reg      <= last_next;
        ret_final_reg <= ret_final_next;
        v0_reg        <= v0_next;
        v1_reg        <= v1_next;
        v2_reg        <= v2_next;
        op0_reg       <= op0_next;
        op1_reg       <= op1_next;
        out_val_reg   <= out_val_next;
        out_err_reg   <= out_err_next;
    end

    always_comb begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        level_next     = level_reg;
        expect_next    = expect_reg;
        err_next       = err_reg;
        ret_final_next = ret_final_reg;
        v0_next        = v0_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        op0_next       = op0_reg;
        op1_next       = op1_reg;
        out_val_next   = out_val_reg;
        out_err_next   = out_err_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        alu_req.start  = 1'b0;
        alu_req.op     = top_op;
        s_tready       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sym_next   = s_tdata;
                    last_next  = s_tlast;
                    state_next = ST_PARSE;
                end
            end
            ST_PARSE: begin
                state_next = tail_state;
                if (err_reg != ERR_NONE || is_space) begin
                    state_next = tail_state;
                end else if (is_digit) begin
                    if (!expect_reg || level_reg > 3'd4) begin
                        err_next = ERR_FORM;
                    end else begin
                        case (level_reg[2:1])
                            2'd0:    v0_next = {4'd0, sym_reg[3:0]};
                            2'd1:    v1_next = {4'd0, sym_reg[3:0]};
                            default: v2_next = {4'd0, sym_reg[3:0]};
                        endcase
                        level_next  = level_reg + 3'd1;
                        expect_next = 1'b0;
                    end
                end else if (is_op) begin
                    if (expect_reg) begin
                        err_next = ERR_FORM;
                    end else begin
                        state_next = ST_OP;
                    end
                end else begin
                    err_next = ERR_CHAR;
                end
            end
            ST_OP: begin
                state_next = tail_state;
                if (err_reg != ERR_NONE) begin
                    state_next = tail_state;
                end else if (need_reduce) begin
                    alu_req.start  = 1'b1;
                    ret_final_next = 1'b0;
                    state_next     = ST_REDUCE;
                end else if (level_reg != 3'd1 && level_reg != 3'd3) begin
                    err_next = ERR_FORM;
                end else begin
                    if (level_reg[1]) begin
                        op1_next = sym_op;
                    end else begin
                        op0_next = sym_op;
                    end
                    level_next  = level_reg + 3'd1;
                    expect_next = 1'b1;
                end
            end
            ST_REDUCE: begin
                if (alu_rsp.done) begin
                    if (alu_rsp.div0) begin
                        err_next = ERR_DIV0;
                    end else begin
                        if (lo) begin
                            v1_next = alu_res;
                        end else begin
                            v0_next = alu_res;
                        end
                        level_next = level_reg - 3'd2;
                    end
                    state_next = ret_final_reg ? ST_FINAL : ST_OP;
                end
            end
            ST_FINAL: begin
                state_next = ST_EMIT;
                if (err_reg == ERR_NONE && (expect_reg || level_reg == 3'd0)) begin
                    err_next = ERR_FORM;
                end else if (err_reg == ERR_NONE && ge3) begin
                    alu_req.start  = 1'b1;
                    ret_final_next = 1'b1;
                    state_next     = ST_REDUCE;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    out_val_next = (err_reg == ERR_NONE) ? v0_reg : 8'd0;
                    out_err_next = err_reg;
                    m_valid_next = 1'b1;
                    level_next   = 3'd0;
                    expect_next  = 1'b1;
                    err_next     = ERR_NONE;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_err_reg, out_val_reg};

endmodule : single_digit_infix_evaluator
`default_nettype wire

/* hdl/sdie_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdie_checker
// Port-level checks for the infix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module sdie_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // ready is low in the cycle after each accepted character
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held high right after an accepted item");

    a_err_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] != 2'd0 |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero value reported with an error");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:10] == 6'd0)
        else $error("padding bits of result not zero");

    // no result rises right after the accept of a non-last item
    a_result_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
        else $error("result raised right after a non-last item");

endmodule : sdie_checker

bind single_digit_infix_evaluator sdie_checker u_sdie_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
